FILE: rtl/core/bkb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkb_pkg: shared types and constants of the knock-out barrier pricer
// Widths, register indexes, reset values, request and result payloads and
// the control and configuration bundles that feed the lattice cells.
// ----------------------------------------------------------------------------
package bkb_pkg;

	localparam int PRICE_W       = 32;
	localparam int DOWN_W        = 31;
	localparam int STEP_W        = 9;
	localparam int STEP_MAX      = 511;
	localparam int CFG_IDX_W     = 3;
	localparam int DEF_MAX_STEPS = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_COUNT  = 3'd0,
		REG_UP_FACTOR   = 3'd1,
		REG_DOWN_FACTOR = 3'd2,
		REG_WEIGHT_UP   = 3'd3,
		REG_WEIGHT_DOWN = 3'd4,
		REG_OPTION_KIND = 3'd5,
		REG_BARRIER_DIR = 3'd6
	} cfg_reg_t;

	localparam logic [STEP_W-1:0]  RST_STEP_COUNT  = 9'd256;
	localparam logic [PRICE_W-1:0] RST_UP_FACTOR   = 32'd1073741824;
	localparam logic [DOWN_W-1:0]  RST_DOWN_FACTOR = 31'd1073741824;
	localparam logic [PRICE_W-1:0] RST_WEIGHT_UP   = 32'd1073741824;
	localparam logic [PRICE_W-1:0] RST_WEIGHT_DOWN = 32'd1073741824;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM,
		ST_PAYOFF,
		ST_ROLL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [PRICE_W-1:0] spot;
		logic [PRICE_W-1:0] strike;
		logic [PRICE_W-1:0] barrier_level;
		logic [PRICE_W-1:0] rebate;
	} req_t;

	typedef struct packed {
		logic [PRICE_W-1:0] option_value;
	} res_t;

	typedef struct packed {
		logic [STEP_W-1:0]  n;
		logic [PRICE_W-1:0] up;
		logic [DOWN_W-1:0]  down;
		logic [PRICE_W-1:0] w_up;
		logic [PRICE_W-1:0] w_down;
		logic               kind;
		logic               dir;
		logic [PRICE_W-1:0] strike;
		logic [PRICE_W-1:0] barrier;
		logic [PRICE_W-1:0] rebate;
	} lat_cfg_t;

	typedef struct packed {
		logic              load;
		logic              term;
		logic              payoff;
		logic              roll;
		logic [STEP_W-1:0] step_k;
		logic [STEP_W-1:0] level;
	} cell_ctl_t;

endpackage

FILE: rtl/core/bkb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkb_if: request and result channels of the knock-out barrier pricer
// Valid/ready channels; a transfer takes place when valid and ready are high.
// ----------------------------------------------------------------------------
interface bkb_req_if;
	logic          valid;
	logic          ready;
	bkb_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bkb_res_if;
	logic          valid;
	logic          ready;
	bkb_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/bkb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkb_cell: one lattice node of the pricing chain
// Holds one node price and one node value. Builds the terminal price by a
// chain of rounded Q2.30 multiplies, sets the terminal payoff, then rolls
// back one level per cycle using the value handed over by its upper neighbor.
// ----------------------------------------------------------------------------
module bkb_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  bkb_pkg::lat_cfg_t           cfg,
	input  bkb_pkg::cell_ctl_t          ctl,
	input  logic [bkb_pkg::PRICE_W-1:0] spot,
	input  logic [bkb_pkg::PRICE_W-1:0] next_value,
	output logic [bkb_pkg::PRICE_W-1:0] value
);

	localparam bit LIVE = (IDX <= bkb_pkg::STEP_MAX);
	localparam logic [bkb_pkg::STEP_W-1:0] IDX_V = bkb_pkg::STEP_W'(IDX);

	logic [bkb_pkg::PRICE_W-1:0] price_q;
	logic [bkb_pkg::PRICE_W-1:0] value_q;
	logic [bkb_pkg::STEP_W-1:0]  ups;
	logic [bkb_pkg::STEP_W-1:0]  pairs;
	logic [bkb_pkg::STEP_W:0]    two_pairs;
	logic [bkb_pkg::PRICE_W-1:0] down_ext;
	logic [bkb_pkg::PRICE_W-1:0] term_factor;
	logic [bkb_pkg::PRICE_W-1:0] mul_factor;
	logic [bkb_pkg::PRICE_W-1:0] price_mul;
	logic [bkb_pkg::PRICE_W-1:0] payoff;
	logic                        active;

	function automatic logic [bkb_pkg::PRICE_W-1:0] mul_q30(
		input logic [bkb_pkg::PRICE_W-1:0] x,
		input logic [bkb_pkg::PRICE_W-1:0] f
	);
		logic [2*bkb_pkg::PRICE_W-1:0] p;
		begin
			p = {32'd0, x} * {32'd0, f} + (64'd1 << 29);
			mul_q30 = (p[63:62] != 2'd0) ? '1 : p[61:30];
		end
	endfunction

	function automatic logic [bkb_pkg::PRICE_W-1:0] blend_q31(
		input logic [bkb_pkg::PRICE_W-1:0] wu,
		input logic [bkb_pkg::PRICE_W-1:0] wd,
		input logic [bkb_pkg::PRICE_W-1:0] va,
		input logic [bkb_pkg::PRICE_W-1:0] vb
	);
		logic [2*bkb_pkg::PRICE_W-1:0] a;
		logic [2*bkb_pkg::PRICE_W-1:0] b;
		logic [2*bkb_pkg::PRICE_W+1:0] s;
		begin
			a = {32'd0, wu} * {32'd0, va};
			b = {32'd0, wd} * {32'd0, vb};
			s = {2'd0, a} + {2'd0, b} + (66'd1 << 30);
			blend_q31 = (s[65:63] != 3'd0) ? '1 : s[62:31];
		end
	endfunction

	function automatic logic touches(
		input logic                        dir,
		input logic [bkb_pkg::PRICE_W-1:0] price,
		input logic [bkb_pkg::PRICE_W-1:0] barrier
	);
		touches = dir ? (price <= barrier) : (price >= barrier);
	endfunction

	// Node i takes min(n-i, i) pairs of down-then-up moves first, then the
	// leftover moves all in one direction.
	always_comb begin
		ups       = cfg.n - IDX_V;
		pairs     = (ups < IDX_V) ? ups : IDX_V;
		two_pairs = {pairs, 1'b0};
		down_ext  = {1'b0, cfg.down};
		if ({1'b0, ctl.step_k} < two_pairs) begin
			term_factor = ctl.step_k[0] ? cfg.up : down_ext;
		end else begin
			term_factor = (ups > IDX_V) ? cfg.up : down_ext;
		end
		mul_factor = ctl.term ? term_factor : down_ext;
		price_mul  = mul_q30(price_q, mul_factor);
		active     = LIVE && (IDX_V < ctl.level);
		if (cfg.kind) begin
			payoff = (cfg.strike > price_q) ? cfg.strike - price_q : '0;
		end else begin
			payoff = (price_q > cfg.strike) ? price_q - cfg.strike : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			price_q <= spot;
		end else if (ctl.term) begin
			price_q <= price_mul;
		end else if (ctl.payoff) begin
			value_q <= touches(cfg.dir, price_q, cfg.barrier) ? cfg.rebate : payoff;
		end else if (ctl.roll && active) begin
			price_q <= price_mul;
			value_q <= touches(cfg.dir, price_mul, cfg.barrier) ? cfg.rebate
				: blend_q31(cfg.w_up, cfg.w_down, value_q, next_value);
		end
	end

	assign value = value_q;

endmodule

FILE: rtl/core/bkb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkb_ctrl: sequencer of the pricing chain
// Steps the cells through load, terminal price build-up, payoff and the
// level-by-level rollback, then hands the root value to the output register.
// ----------------------------------------------------------------------------
module bkb_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bkb_pkg::STEP_W-1:0] n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       res_full,
	input  logic                       res_ready,
	output logic                       load_res,
	output bkb_pkg::cell_ctl_t         ctl
);

	bkb_pkg::seq_state_t        state_q;
	bkb_pkg::seq_state_t        state_d;
	logic [bkb_pkg::STEP_W-1:0] step_k_q;
	logic [bkb_pkg::STEP_W-1:0] step_k_d;
	logic [bkb_pkg::STEP_W-1:0] level_q;
	logic [bkb_pkg::STEP_W-1:0] level_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bkb_pkg::ST_IDLE;
			step_k_q <= '0;
			level_q  <= '0;
		end else begin
			state_q  <= state_d;
			step_k_q <= step_k_d;
			level_q  <= level_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		step_k_d   = step_k_q;
		level_d    = level_q;
		req_ready  = 1'b0;
		load_res   = 1'b0;
		ctl        = '0;
		ctl.step_k = step_k_q;
		ctl.level  = level_q;
		case (state_q)
			bkb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					step_k_d = '0;
					state_d  = bkb_pkg::ST_TERM;
				end
			end
			bkb_pkg::ST_TERM: begin
				ctl.term = 1'b1;
				if (step_k_q == n - bkb_pkg::STEP_W'(1)) begin
					state_d = bkb_pkg::ST_PAYOFF;
				end else begin
					step_k_d = step_k_q + bkb_pkg::STEP_W'(1);
				end
			end
			bkb_pkg::ST_PAYOFF: begin
				ctl.payoff = 1'b1;
				level_d    = n;
				state_d    = bkb_pkg::ST_ROLL;
			end
			bkb_pkg::ST_ROLL: begin
				ctl.roll = 1'b1;
				level_d  = level_q - bkb_pkg::STEP_W'(1);
				if (level_q == bkb_pkg::STEP_W'(1)) begin
					state_d = bkb_pkg::ST_DONE;
				end
			end
			bkb_pkg::ST_DONE: begin
				// Wait here only if the previous result has not been taken yet.
				if (!res_full || res_ready) begin
					load_res = 1'b1;
					state_d  = bkb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bkb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/binomial_knockout_barrier_pricer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_knockout_barrier_pricer: knock-out barrier option on a lattice
// Prices one request (spot, strike, barrier level, rebate) per transfer on
// req and returns the root node value as one transfer on res. Software must
// set step count n, u, d, the two discounted weights, call/put and the
// barrier direction through the write port while the block is idle; the
// block itself does not enforce this. A row of MAX_STEPS+1 cells holds
// the lattice. After a request transfer the cells build terminal prices
// (one rounded multiply per cycle in each cell), set the payoff and roll
// back, one level per cycle. The root value then goes to the output
// register; the next request is accepted only once the sequencer is idle.
// The result sits in an output register, so a new request is accepted
// while res is stalled; a finished result then waits until res is free.
// Reset clears the sequencer and the output valid and sets every
// configuration register to its default (n = 256, unit factors and weights
// of one half, call, up-and-out).
// ----------------------------------------------------------------------------
module binomial_knockout_barrier_pricer #(
	parameter int MAX_STEPS = bkb_pkg::DEF_MAX_STEPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bkb_req_if.sink                       req,
	bkb_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [bkb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bkb_pkg::PRICE_W-1:0]   cfg_data
);

	logic [bkb_pkg::STEP_W-1:0]  step_count_q;
	logic [bkb_pkg::PRICE_W-1:0] up_factor_q;
	logic [bkb_pkg::DOWN_W-1:0]  down_factor_q;
	logic [bkb_pkg::PRICE_W-1:0] weight_up_q;
	logic [bkb_pkg::PRICE_W-1:0] weight_down_q;
	logic                        option_kind_q;
	logic                        barrier_dir_q;
	logic [bkb_pkg::PRICE_W-1:0] strike_q;
	logic [bkb_pkg::PRICE_W-1:0] barrier_q;
	logic [bkb_pkg::PRICE_W-1:0] rebate_q;
	logic [bkb_pkg::PRICE_W-1:0] res_value_q;
	logic                        res_valid_q;
	logic [bkb_pkg::STEP_W-1:0]  n_eff;
	logic                        load_res;
	bkb_pkg::lat_cfg_t           lat_cfg;
	bkb_pkg::cell_ctl_t          ctl;
	logic [bkb_pkg::PRICE_W-1:0] chain_val [MAX_STEPS+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q  <= bkb_pkg::RST_STEP_COUNT;
			up_factor_q   <= bkb_pkg::RST_UP_FACTOR;
			down_factor_q <= bkb_pkg::RST_DOWN_FACTOR;
			weight_up_q   <= bkb_pkg::RST_WEIGHT_UP;
			weight_down_q <= bkb_pkg::RST_WEIGHT_DOWN;
			option_kind_q <= 1'b0;
			barrier_dir_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bkb_pkg::REG_STEP_COUNT:  step_count_q  <= cfg_data[bkb_pkg::STEP_W-1:0];
				bkb_pkg::REG_UP_FACTOR:   up_factor_q   <= cfg_data;
				bkb_pkg::REG_DOWN_FACTOR: down_factor_q <= cfg_data[bkb_pkg::DOWN_W-1:0];
				bkb_pkg::REG_WEIGHT_UP:   weight_up_q   <= cfg_data;
				bkb_pkg::REG_WEIGHT_DOWN: weight_down_q <= cfg_data;
				bkb_pkg::REG_OPTION_KIND: option_kind_q <= cfg_data[0];
				bkb_pkg::REG_BARRIER_DIR: barrier_dir_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Zero steps runs as one step; anything beyond the chain length is clipped.
	always_comb begin
		if (step_count_q == '0) begin
			n_eff = bkb_pkg::STEP_W'(1);
		end else if (int'(step_count_q) > MAX_STEPS) begin
			n_eff = bkb_pkg::STEP_W'(MAX_STEPS);
		end else begin
			n_eff = step_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			strike_q  <= req.data.strike;
			barrier_q <= req.data.barrier_level;
			rebate_q  <= req.data.rebate;
		end
		if (load_res) begin
			res_value_q <= chain_val[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		lat_cfg.n       = n_eff;
		lat_cfg.up      = up_factor_q;
		lat_cfg.down    = down_factor_q;
		lat_cfg.w_up    = weight_up_q;
		lat_cfg.w_down  = weight_down_q;
		lat_cfg.kind    = option_kind_q;
		lat_cfg.dir     = barrier_dir_q;
		lat_cfg.strike  = strike_q;
		lat_cfg.barrier = barrier_q;
		lat_cfg.rebate  = rebate_q;
	end

	bkb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_eff),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_full  (res_valid_q),
		.res_ready (res.ready),
		.load_res  (load_res),
		.ctl       (ctl)
	);

	// The top cell never rolls back, so its upper neighbor is a constant.
	assign chain_val[MAX_STEPS+1] = '0;

	for (genvar gi = 0; gi <= MAX_STEPS; gi++) begin : g_cell
		bkb_cell #(
			.IDX (gi)
		) u_cell (
			.clk        (clk),
			.cfg        (lat_cfg),
			.ctl        (ctl),
			.spot       (req.data.spot),
			.next_value (chain_val[gi+1]),
			.value      (chain_val[gi])
		);
	end

	assign res.valid             = res_valid_q;
	assign res.data.option_value = res_value_q;

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!res_valid_q || res.ready))
		else $error("result register loaded while holding an untaken result");

	a_accept_starts_term: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (ctl.term && ctl.step_k == '0))
		else $error("request transfer did not start the terminal phase");

	a_term_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.term |-> (ctl.step_k < n_eff))
		else $error("terminal step count ran past the step count");

	a_roll_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.roll |-> (ctl.level != '0 && ctl.level <= n_eff))
		else $error("rollback level out of range");

endmodule
